>>> rtl/core/radix_digit_emitter_top_macros.svh
// Assertion macros shared by the radix digit emitter modules.
`ifndef RADIX_DIGIT_EMITTER_TOP_MACROS_SVH
`define RADIX_DIGIT_EMITTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rde_pkg.sv
// Package with the shared constants, types and functions of the radix digit emitter.
`default_nettype none

package rde_pkg;

    // Default width of the converted value.
    localparam int RDE_VALUE_WIDTH = 64;

    // Field widths of the channels.
    localparam int RDE_IN_VALUE_W = 64;
    localparam int RDE_RADIX_W    = 5;
    localparam int RDE_DIGIT_W    = 4;
    localparam int RDE_CHAR_W     = 8;
    localparam int RDE_S_TDATA_W  = 72;
    localparam int RDE_M_TDATA_W  = 8;

    // Quotient bits produced by the divider in one cycle.
    localparam int RDE_STEP_BITS = 8;

    // Legal range of the base.
    localparam logic [RDE_RADIX_W-1:0] RDE_RADIX_MIN = 5'd2;
    localparam logic [RDE_RADIX_W-1:0] RDE_RADIX_MAX = 5'd16;

    // ASCII offsets of the digit classes.
    localparam logic [RDE_CHAR_W-1:0] RDE_CHAR_ZERO     = 8'h30;
    localparam logic [RDE_CHAR_W-1:0] RDE_CHAR_LOWER_OF = 8'h57;
    localparam logic [RDE_CHAR_W-1:0] RDE_CHAR_UPPER_OF = 8'h37;
    localparam logic [RDE_DIGIT_W-1:0] RDE_DIGIT_TEN    = 4'd10;

    // Command to the shared divider.
    typedef struct packed {
        logic                   start;
        logic [RDE_RADIX_W-1:0] divisor;
    } rde_div_cmd_t;

    // Clamp the requested base into the legal range.
    function automatic logic [RDE_RADIX_W-1:0] rde_radix_sat(
        input logic [RDE_RADIX_W-1:0] radix
    );
        logic [RDE_RADIX_W-1:0] r;
        r = radix;
        if (radix < RDE_RADIX_MIN) begin
            r = RDE_RADIX_MIN;
        end else if (radix > RDE_RADIX_MAX) begin
            r = RDE_RADIX_MAX;
        end
        return r;
    endfunction

    // ASCII code of one digit value.
    function automatic logic [RDE_CHAR_W-1:0] rde_digit_char(
        input logic [RDE_DIGIT_W-1:0] d,
        input logic                   lower
    );
        logic [RDE_CHAR_W-1:0] offs;
        if (d < RDE_DIGIT_TEN) begin
            offs = RDE_CHAR_ZERO;
        end else if (lower) begin
            offs = RDE_CHAR_LOWER_OF;
        end else begin
            offs = RDE_CHAR_UPPER_OF;
        end
        return offs + RDE_CHAR_W'(d);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/radix_digit_emitter_top.sv
// Top level of the radix digit emitter: sequencer, output register and shared divider.
//
// Usage: one item on the s_ channel carries a value, a base and a letter-case flag.
// The block answers with one item per digit on the m_ channel, least significant
// digit first; m_tlast marks the most significant, final digit. A zero value gives
// the single digit '0'. Bases below 2 act as 2, bases above 16 act as 16.
// s_tready is high only while no conversion is in progress, so one item is worked
// on at a time. Each digit comes from one pass of the shared divider, which retires
// 8 quotient bits per cycle. The first digit enters the output register once the
// first division is done.
// The final digit sits in the output register while a new item may be accepted.
// When the receiver stalls, the current digit holds in the output register and the
// divider waits before it starts the next digit.
// Reset (aresetn low, synchronous) empties the output register, returns the
// sequencer to idle and clears the divider's step counter and completion flag.
`default_nettype none

`include "radix_digit_emitter_top_macros.svh"

module radix_digit_emitter_top #(
    parameter int VALUE_WIDTH = rde_pkg::RDE_VALUE_WIDTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata fields from bit 0: value[63:0], radix[68:64], zero fill [71:69]
    input  wire logic [rde_pkg::RDE_S_TDATA_W-1:0] s_tdata,
    // s_tuser fields from bit 0: lowercase
    input  wire logic                              s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // m_tdata fields from bit 0: digit_char[7:0]
    output logic      [rde_pkg::RDE_M_TDATA_W-1:0] m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready
);
    import rde_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [RDE_RADIX_W-1:0] base_reg;
    logic                   lower_reg;
    logic                   m_valid_reg;
    logic [RDE_CHAR_W-1:0]  m_char_reg;
    logic                   m_last_reg;

    rde_div_cmd_t           div_cmd;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [RDE_DIGIT_W-1:0] div_rem;
    logic                   div_done;

    logic                   s_accept;
    logic                   out_free;
    logic                   out_load;
    logic                   is_last;
    logic [RDE_RADIX_W-1:0] in_base;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign is_last  = (div_quot == '0);
    assign in_base  = rde_radix_sat(s_tdata[RDE_IN_VALUE_W +: RDE_RADIX_W]);

    // Sequencer: start a division, wait for it, hand the digit to the output.
    always_comb begin
        state_next      = state_reg;
        div_cmd.start   = 1'b0;
        div_cmd.divisor = base_reg;
        div_dividend    = div_quot;
        out_load        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                div_dividend    = s_tdata[VALUE_WIDTH-1:0];
                div_cmd.divisor = in_base;
                if (s_accept) begin
                    div_cmd.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        div_cmd.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item settings and output payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            base_reg  <= in_base;
            lower_reg <= s_tuser;
        end
        if (out_load) begin
            m_char_reg <= rde_digit_char(div_rem, lower_reg);
            m_last_reg <= is_last;
        end
    end

    rde_div_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (div_cmd),
        .dividend  (div_dividend),
        .quotient  (div_quot),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;
    assign m_tvalid = m_valid_reg;

    // Handing over the final digit frees the block for the next item.
    `RDE_ASSERT_NXT(a_last_frees_input, aclk, aresetn,
        out_load && is_last, s_tready, "input not ready after final digit")
    // The divider only reports completion while the sequencer waits for it.
    `RDE_ASSERT_IMP(a_done_in_div, aclk, aresetn,
        div_done, state_reg == ST_DIV, "divider completion outside divide state")
    // The stored base stays in the legal range while converting.
    `RDE_ASSERT_IMP(a_base_in_range, aclk, aresetn,
        state_reg != ST_IDLE, (base_reg >= RDE_RADIX_MIN) && (base_reg <= RDE_RADIX_MAX),
        "base out of range during conversion")

endmodule

`default_nettype wire

>>> rtl/core/rde_div_unit.sv
// Shared radix-2 restoring divider that retires several quotient bits per cycle.
`default_nettype none

`include "radix_digit_emitter_top_macros.svh"

module rde_div_unit #(
    parameter int VALUE_WIDTH = rde_pkg::RDE_VALUE_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire rde_pkg::rde_div_cmd_t          cmd,
    input  wire logic [VALUE_WIDTH-1:0]         dividend,
    output logic      [VALUE_WIDTH-1:0]         quotient,
    output logic      [rde_pkg::RDE_DIGIT_W-1:0] remainder,
    output logic                                done
);
    import rde_pkg::*;

    // Dividend padded to a whole number of steps.
    localparam int STEPS = (VALUE_WIDTH + RDE_STEP_BITS - 1) / RDE_STEP_BITS;
    localparam int PAD_W = STEPS * RDE_STEP_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0]       work_reg, work_next;
    logic [RDE_DIGIT_W-1:0] rem_reg, rem_next;
    logic [RDE_RADIX_W-1:0] divisor_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   done_reg;

    logic [PAD_W-1:0]       w_v;
    logic [RDE_DIGIT_W-1:0] r_v;
    logic [RDE_RADIX_W-1:0] t_v;

    // One step of the long division: for each of RDE_STEP_BITS bits, shift in a dividend bit, subtract when it fits.
    always_comb begin
        w_v = work_reg;
        r_v = rem_reg;
        t_v = '0;
        for (int i = 0; i < RDE_STEP_BITS; i++) begin
            t_v = {r_v, w_v[PAD_W-1]};
            w_v = {w_v[PAD_W-2:0], 1'b0};
            if (t_v >= divisor_reg) begin
                t_v    = t_v - divisor_reg;
                w_v[0] = 1'b1;
            end
            r_v = t_v[RDE_DIGIT_W-1:0];
        end
        work_next = w_v;
        rem_next  = r_v;
    end

    // Step counter and completion flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1)) && !cmd.start;
            if (cmd.start) begin
                cnt_reg <= CNT_W'(STEPS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Working dividend, partial remainder and divisor.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            work_reg    <= PAD_W'(dividend);
            rem_reg     <= '0;
            divisor_reg <= cmd.divisor;
        end else if (cnt_reg != '0) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient  = work_reg[VALUE_WIDTH-1:0];
    assign remainder = rem_reg;
    assign done      = done_reg;

    // The last step of a division raises the completion flag.
    `RDE_ASSERT_NXT(a_done_after_last_step, aclk, aresetn,
        (cnt_reg == CNT_W'(1)) && !cmd.start, done_reg, "divider missed its completion")
    // A finished division leaves a remainder below the divisor.
    `RDE_ASSERT_IMP(a_rem_below_divisor, aclk, aresetn,
        done_reg, RDE_RADIX_W'(rem_reg) < divisor_reg, "remainder not below divisor")
    // Completion is only flagged once the step counter has run out.
    `RDE_ASSERT_IMP(a_done_idle_counter, aclk, aresetn,
        done_reg, cnt_reg == '0, "completion flagged while still stepping")

endmodule

`default_nettype wire
